// File: src/spq_pkg.sv
// shared types and constants for the sorted priority task queue
`default_nettype none
package spq_pkg;

    localparam int CAPACITY_DEF = 16;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_POP    = 2'd1,
        OP_DUMP   = 2'd2,
        OP_MODIFY = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic [15:0]        tag;
        logic signed [15:0] prio;
        logic [15:0]        dur;
    } t_entry;

endpackage
`default_nettype wire

// File: src/sorted_priority_task_queue_top.sv
// sorted priority task queue: command sequencer, task count and result register
// usage:
//   input channel i_valid / o_stall carries one command word (insert, pop,
//   dump, modify); output channel o_valid / i_stall carries result words.
//   tasks are kept in a single-port-read memory in ascending priority order,
//   equal priorities in arrival order.
//   commands are taken one at a time; o_stall is high while one is in work.
//   steps per command (n = stored tasks, one memory read per step, each step
//   a read state and an evaluate state because the read data is registered):
//     insert    one step per task above the new one, one more unless at the head
//     pop       head read and result, then n - 1 shift-down steps
//     dump      n steps, one result word per step
//     modify    scan to match, shift down, then insert (no match: insert only)
//   empty cases and insert on a full queue answer without a memory read.
//   results sit in an output register; while o_valid and i_stall are high the
//   register holds and the sequencer waits before producing the next result.
//   reset (i_rst_n low, synchronous) empties the queue and the result
//   register; memory contents are not cleared, only the count matters.
`default_nettype none
module sorted_priority_task_queue_top #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [1:0]         i_opcode,
    input  wire logic [15:0]        i_task_tag,
    input  wire logic signed [15:0] i_task_priority,
    input  wire logic [15:0]        i_task_duration,
    input  wire logic signed [15:0] i_match_priority,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [1:0]              o_status,
    output logic                    o_has_entry,
    output logic [15:0]             o_out_tag,
    output logic signed [15:0]      o_out_priority,
    output logic [15:0]             o_out_duration,
    output logic                    o_last
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE_C = CW'(1);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_INS_RD = 10'b0000000010,
        S_INS_EV = 10'b0000000100,
        S_SHD_RD = 10'b0000001000,
        S_SHD_EV = 10'b0000010000,
        S_POP_EV = 10'b0000100000,
        S_DMP_RD = 10'b0001000000,
        S_DMP_EV = 10'b0010000000,
        S_MOD_RD = 10'b0100000000,
        S_MOD_EV = 10'b1000000000
    } t_state;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_k, n_k;
    logic                r_mod, n_mod;
    logic                r_resp, n_resp;
    spq_pkg::t_status    r_rstat, n_rstat;
    spq_pkg::t_entry     r_new, n_new;
    logic signed [15:0]  r_match, n_match;

    logic                r_ov, n_ov;
    logic [1:0]          r_ost, n_ost;
    logic                r_ohas, n_ohas;
    spq_pkg::t_entry     r_oent, n_oent;
    logic                r_olast, n_olast;

    logic                rd_en, wr_en;
    logic [AW-1:0]       rd_addr, wr_addr;
    spq_pkg::t_entry     rd_data, wr_data;
    logic                in_acc, o_free;
    logic [CW-1:0]       km1, kp1, cm1;

    spq_mem #(.DEPTH(CAPACITY), .AW(AW)) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    assign o_stall = (r_state != S_IDLE) || r_resp;
    assign in_acc  = i_valid && !o_stall;
    assign o_free  = !r_ov || !i_stall;
    assign km1     = r_k - ONE_C;
    assign kp1     = r_k + ONE_C;
    assign cm1     = r_count - ONE_C;

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_k     = r_k;
        n_mod   = r_mod;
        n_resp  = r_resp;
        n_rstat = r_rstat;
        n_new   = r_new;
        n_match = r_match;
        n_ov    = r_ov && i_stall;
        n_ost   = r_ost;
        n_ohas  = r_ohas;
        n_oent  = r_oent;
        n_olast = r_olast;
        rd_en   = 1'b0;
        rd_addr = r_k[AW-1:0];
        wr_en   = 1'b0;
        wr_addr = r_k[AW-1:0];
        wr_data = r_new;

        case (r_state)
            S_IDLE: begin
                if (r_resp && o_free) begin
                    n_resp  = 1'b0;
                    n_ov    = 1'b1;
                    n_ost   = r_rstat;
                    n_ohas  = 1'b0;
                    n_oent  = '0;
                    n_olast = 1'b1;
                end else if (in_acc) begin
                    n_new   = '{tag: i_task_tag, prio: i_task_priority, dur: i_task_duration};
                    n_match = i_match_priority;
                    n_mod   = 1'b0;
                    case (spq_pkg::t_op'(i_opcode))
                        spq_pkg::OP_INSERT: begin
                            if (r_count == CAP_C) begin
                                n_resp  = 1'b1;
                                n_rstat = spq_pkg::ST_FULL;
                            end else begin
                                n_k     = r_count;
                                n_state = S_INS_RD;
                            end
                        end
                        spq_pkg::OP_POP: begin
                            if (r_count == '0) begin
                                n_resp  = 1'b1;
                                n_rstat = spq_pkg::ST_EMPTY;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = '0;
                                n_state = S_POP_EV;
                            end
                        end
                        spq_pkg::OP_DUMP: begin
                            if (r_count == '0) begin
                                n_resp  = 1'b1;
                                n_rstat = spq_pkg::ST_EMPTY;
                            end else begin
                                n_k     = '0;
                                n_state = S_DMP_RD;
                            end
                        end
                        default: begin
                            if (r_count == '0) begin
                                n_resp  = 1'b1;
                                n_rstat = spq_pkg::ST_EMPTY;
                            end else begin
                                n_k     = '0;
                                n_state = S_MOD_RD;
                            end
                        end
                    endcase
                end
            end
            S_INS_RD: begin
                if (r_k == '0) begin
                    wr_en   = 1'b1;
                    n_count = r_count + ONE_C;
                    n_resp  = 1'b1;
                    n_rstat = spq_pkg::ST_OK;
                    n_state = S_IDLE;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = km1[AW-1:0];
                    n_state = S_INS_EV;
                end
            end
            S_INS_EV: begin
                wr_en = 1'b1;
                if (rd_data.prio > r_new.prio) begin
                    wr_data = rd_data;
                    n_k     = km1;
                    n_state = S_INS_RD;
                end else begin
                    n_count = r_count + ONE_C;
                    n_resp  = 1'b1;
                    n_rstat = spq_pkg::ST_OK;
                    n_state = S_IDLE;
                end
            end
            S_POP_EV: begin
                if (o_free) begin
                    n_ov    = 1'b1;
                    n_ost   = spq_pkg::ST_OK;
                    n_ohas  = 1'b1;
                    n_oent  = rd_data;
                    n_olast = 1'b1;
                    n_k     = ONE_C;
                    n_state = S_SHD_RD;
                end
            end
            S_SHD_RD: begin
                if (r_k >= r_count) begin
                    n_count = cm1;
                    if (r_mod) begin
                        n_k     = cm1;
                        n_state = S_INS_RD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else begin
                    rd_en   = 1'b1;
                    n_state = S_SHD_EV;
                end
            end
            S_SHD_EV: begin
                wr_en   = 1'b1;
                wr_addr = km1[AW-1:0];
                wr_data = rd_data;
                n_k     = kp1;
                n_state = S_SHD_RD;
            end
            S_DMP_RD: begin
                rd_en   = 1'b1;
                n_state = S_DMP_EV;
            end
            S_DMP_EV: begin
                if (o_free) begin
                    n_ov    = 1'b1;
                    n_ost   = spq_pkg::ST_OK;
                    n_ohas  = 1'b1;
                    n_oent  = rd_data;
                    n_olast = (kp1 == r_count);
                    n_k     = kp1;
                    n_state = (kp1 == r_count) ? S_IDLE : S_DMP_RD;
                end
            end
            S_MOD_RD: begin
                if (r_k == r_count) begin
                    if (r_count == CAP_C) begin
                        n_resp  = 1'b1;
                        n_rstat = spq_pkg::ST_FULL;
                        n_state = S_IDLE;
                    end else begin
                        n_k     = r_count;
                        n_state = S_INS_RD;
                    end
                end else begin
                    rd_en   = 1'b1;
                    n_state = S_MOD_EV;
                end
            end
            S_MOD_EV: begin
                n_k = kp1;
                if (rd_data.prio == r_match) begin
                    n_mod   = 1'b1;
                    n_state = S_SHD_RD;
                end else begin
                    n_state = S_MOD_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_resp  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_resp  <= n_resp;
            r_ov    <= n_ov;
        end
        r_k     <= n_k;
        r_mod   <= n_mod;
        r_rstat <= n_rstat;
        r_new   <= n_new;
        r_match <= n_match;
        r_ost   <= n_ost;
        r_ohas  <= n_ohas;
        r_oent  <= n_oent;
        r_olast <= n_olast;
    end

    assign o_valid        = r_ov;
    assign o_status       = r_ost;
    assign o_has_entry    = r_ohas;
    assign o_out_tag      = r_oent.tag;
    assign o_out_priority = r_oent.prio;
    assign o_out_duration = r_oent.dur;
    assign o_last         = r_olast;

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_C)
        else $error("task count above capacity");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_stall)
        else $error("command accepted without going busy");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (CW'(wr_addr) <= r_count))
        else $error("write beyond stored tasks");

    a_empty_no_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP_EV) |-> (r_count != '0))
        else $error("pop on empty queue");

endmodule
`default_nettype wire

// File: src/spq_mem.sv
// task store: one write port, one registered read port
`default_nettype none
module spq_mem #(
    parameter int DEPTH = spq_pkg::CAPACITY_DEF,
    parameter int AW    = $clog2(spq_pkg::CAPACITY_DEF)
) (
    input  wire logic           i_clk,
    input  wire logic           i_rd_en,
    input  wire logic [AW-1:0]  i_rd_addr,
    output spq_pkg::t_entry     o_rd_data,
    input  wire logic           i_wr_en,
    input  wire logic [AW-1:0]  i_wr_addr,
    input  wire spq_pkg::t_entry i_wr_data
);

    spq_pkg::t_entry r_mem [DEPTH];
    spq_pkg::t_entry r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd;

endmodule
`default_nettype wire
